// ===== rtl/glmf_pkg.sv =====
package glmf_pkg;

	localparam int MAX_COLS   = 1024;
	localparam int MAX_ROWS   = 1024;
	localparam int VALUE_BITS = 16;
	localparam int COL_BITS   = $clog2(MAX_COLS);
	localparam int ROW_BITS   = $clog2(MAX_ROWS);
	localparam int REG_BITS   = 11;
	localparam int CNT_BITS   = 16;
	localparam int IDX_BITS   = 2;
	localparam int QDEPTH     = 4;
	localparam int QPTR_BITS  = $clog2(QDEPTH);

	// Register indexes of the configuration port.
	localparam logic [IDX_BITS-1:0] REG_GRID_ROWS  = 2'd0;
	localparam logic [IDX_BITS-1:0] REG_GRID_COLS  = 2'd1;
	localparam logic [IDX_BITS-1:0] REG_TARGET_ROW = 2'd2;
	localparam logic [IDX_BITS-1:0] REG_TARGET_COL = 2'd3;

	// Result item kinds.
	localparam logic KIND_PEAK    = 1'b0;
	localparam logic KIND_SUMMARY = 1'b1;

	// Bits of a job mask, in the order the results leave the block.
	localparam int JB_MID_LEFT  = 0;
	localparam int JB_LOW_LEFT  = 1;
	localparam int JB_MID_RIGHT = 2;
	localparam int JB_LOW_RIGHT = 3;
	localparam int JB_SUMMARY   = 4;
	localparam int JOB_BITS     = 5;

	typedef struct packed {
		logic [REG_BITS-1:0] grid_rows;
		logic [REG_BITS-1:0] grid_cols;
		logic [REG_BITS-1:0] target_row;
		logic [REG_BITS-1:0] target_col;
	} glmf_cfg_t;

	// One classified input: which results it causes and where.
	typedef struct packed {
		logic [JOB_BITS-1:0] mask;
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
	} glmf_job_t;

	typedef struct packed {
		logic full;
		logic empty;
	} glmf_qstat_t;

	typedef logic [7:0][VALUE_BITS-1:0] glmf_nb_t;

	// Center is a peak when it is strictly greater than every enabled neighbor.
	function automatic logic is_peak(logic [VALUE_BITS-1:0] ctr, glmf_nb_t nb,
		logic [7:0] en);
		logic ok;
		ok = 1'b1;
		for (int i = 0; i < 8; i++) begin
			if (en[i] && !($signed(ctr) > $signed(nb[i]))) begin
				ok = 1'b0;
			end
		end
		return ok;
	endfunction

endpackage

// ===== rtl/glmf_front.sv =====
module glmf_front import glmf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  glmf_cfg_t             cfg,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] cell_value,
	input  logic                  q_full,
	output logic                  push,
	output glmf_job_t             push_job
);

	logic [2*VALUE_BITS-1:0] line_mem [MAX_COLS];
	logic [2*VALUE_BITS-1:0] rd_q;

	logic [ROW_BITS-1:0]   pos_r_q;
	logic [COL_BITS-1:0]   pos_c_q;
	logic                  v_s1;
	logic [VALUE_BITS-1:0] val_s1;
	logic [ROW_BITS-1:0]   r_s1;
	logic [COL_BITS-1:0]   c_s1;
	logic                  last_row_s1;
	logic                  row_end_s1;

	logic [2:0][VALUE_BITS-1:0] col_a_q;
	logic [2:0][VALUE_BITS-1:0] col_b_q;
	logic [2:0][VALUE_BITS-1:0] fresh;

	logic [REG_BITS-1:0] rows_cl, cols_cl, r_cl, c_cl;
	logic                accept, advance, last_row, row_end;
	logic                up, left, has_r, has_c;
	logic [3:0]          pk;
	glmf_nb_t            nb0, nb1, nb2, nb3;
	logic [JOB_BITS-1:0] mask;

	// Clamp the grid size and the current position to the legal range.
	always_comb begin
		rows_cl = (cfg.grid_rows < REG_BITS'(2)) ? REG_BITS'(2) :
			((cfg.grid_rows > REG_BITS'(MAX_ROWS)) ? REG_BITS'(MAX_ROWS) : cfg.grid_rows);
		cols_cl = (cfg.grid_cols < REG_BITS'(2)) ? REG_BITS'(2) :
			((cfg.grid_cols > REG_BITS'(MAX_COLS)) ? REG_BITS'(MAX_COLS) : cfg.grid_cols);
		r_cl = (REG_BITS'(pos_r_q) > rows_cl - 1'b1) ? rows_cl - 1'b1 : REG_BITS'(pos_r_q);
		c_cl = (REG_BITS'(pos_c_q) > cols_cl - 1'b1) ? cols_cl - 1'b1 : REG_BITS'(pos_c_q);
		last_row = (r_cl == rows_cl - 1'b1);
		row_end  = (c_cl == cols_cl - 1'b1);
	end

	assign advance  = v_s1 && !q_full;
	assign in_stall = v_s1 && q_full;
	assign accept   = in_valid && !in_stall;

	// Raster position counters, stepped on every input transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_r_q <= '0;
			pos_c_q <= '0;
		end else if (accept) begin
			if (last_row && row_end) begin
				pos_r_q <= '0;
				pos_c_q <= '0;
			end else if (row_end) begin
				pos_r_q <= ROW_BITS'(r_cl + 1'b1);
				pos_c_q <= '0;
			end else begin
				pos_r_q <= ROW_BITS'(r_cl);
				pos_c_q <= COL_BITS'(c_cl + 1'b1);
			end
		end
	end

	// Stage one holds the accepted cell while its column is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (accept) begin
			v_s1 <= 1'b1;
		end else if (advance) begin
			v_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			val_s1      <= cell_value;
			r_s1        <= ROW_BITS'(r_cl);
			c_s1        <= COL_BITS'(c_cl);
			last_row_s1 <= last_row;
			row_end_s1  <= row_end;
		end
	end

	// Line store: upper row in the high half, middle row in the low half.
	always_ff @(posedge clk) begin
		if (accept) begin
			rd_q <= line_mem[COL_BITS'(c_cl)];
		end
		if (advance) begin
			line_mem[c_s1] <= {rd_q[VALUE_BITS-1:0], val_s1};
		end
	end

	assign fresh = {val_s1, rd_q[VALUE_BITS-1:0], rd_q[2*VALUE_BITS-1:VALUE_BITS]};

	// Window columns shift left as each cell leaves stage one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_a_q <= '0;
			col_b_q <= '0;
		end else if (advance) begin
			col_a_q <= col_b_q;
			col_b_q <= fresh;
		end
	end

	// Decide the up to four cells whose neighborhoods are now complete, and the summary.
	always_comb begin
		up    = (r_s1 >= ROW_BITS'(2));
		left  = (c_s1 >= COL_BITS'(2));
		has_r = (r_s1 != '0);
		has_c = (c_s1 != '0);
		nb0 = {col_a_q[0], col_b_q[0], fresh[0], col_a_q[1], fresh[1],
			col_a_q[2], col_b_q[2], fresh[2]};
		nb1 = {col_a_q[1], col_b_q[1], fresh[1], col_a_q[2], fresh[2],
			{3{VALUE_BITS'(0)}}};
		nb2 = {col_b_q[0], fresh[0], col_b_q[1], col_b_q[2], fresh[2],
			{3{VALUE_BITS'(0)}}};
		nb3 = {col_b_q[1], fresh[1], col_b_q[2], {5{VALUE_BITS'(0)}}};
		pk[0] = is_peak(col_b_q[1], nb0,
			{up && left, up, up, left, 1'b1, left, 1'b1, 1'b1});
		pk[1] = is_peak(col_b_q[2], nb1, {left, 1'b1, 1'b1, left, 1'b1, 3'b000});
		pk[2] = is_peak(fresh[1], nb2, {up, up, 1'b1, 1'b1, 1'b1, 3'b000});
		pk[3] = is_peak(fresh[2], nb3, {3'b111, 5'b00000});
		mask = '0;
		mask[JB_MID_LEFT]  = has_r && has_c && pk[0];
		mask[JB_LOW_LEFT]  = has_r && has_c && last_row_s1 && pk[1];
		mask[JB_MID_RIGHT] = has_r && row_end_s1 && pk[2];
		mask[JB_LOW_RIGHT] = has_r && row_end_s1 && last_row_s1 && pk[3];
		mask[JB_SUMMARY]   = last_row_s1 && row_end_s1;
	end

	assign push          = advance && (mask != '0);
	assign push_job.mask = mask;
	assign push_job.row  = r_s1;
	assign push_job.col  = c_s1;

endmodule

// ===== rtl/glmf_queue.sv =====
module glmf_queue import glmf_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	input  glmf_job_t   push_job,
	input  logic        pop,
	output glmf_job_t   head_job,
	output glmf_qstat_t stat
);

	glmf_job_t            slot_q [QDEPTH];
	logic [QPTR_BITS-1:0] wr_q, rd_q;
	logic [QPTR_BITS:0]   cnt_q;

	assign stat.full  = (cnt_q == (QPTR_BITS+1)'(QDEPTH));
	assign stat.empty = (cnt_q == '0);
	assign head_job   = slot_q[rd_q];

	// Pointers and occupancy of the job queue.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_job;
		end
	end

endmodule

// ===== rtl/glmf_back.sv =====
module glmf_back import glmf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  glmf_cfg_t           cfg,
	input  glmf_job_t           head_job,
	input  logic                q_empty,
	output logic                pop,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                item_kind,
	output logic [REG_BITS-1:0] peak_row,
	output logic [REG_BITS-1:0] peak_col,
	output logic [CNT_BITS-1:0] peak_ordinal,
	output logic                target_is_peak,
	output logic                last_of_run
);

	logic [JOB_BITS-1:0] mask_q;
	logic [ROW_BITS-1:0] row_q;
	logic [COL_BITS-1:0] col_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                hit_q;
	logic                out_valid_q;

	logic [JOB_BITS-1:0] sel, rest;
	logic                emit, load;
	logic [REG_BITS-1:0] e_row, e_col;
	logic [CNT_BITS-1:0] cnt_inc;

	// Pick the next result of the current job, lowest mask bit first.
	always_comb begin
		sel   = mask_q & (~mask_q + 1'b1);
		rest  = mask_q & ~sel;
		emit  = (mask_q != '0) && (!out_valid_q || !out_stall);
		load  = ((mask_q == '0) || (emit && rest == '0)) && !q_empty;
		pop   = load;
		e_row = REG_BITS'(row_q);
		e_col = REG_BITS'(col_q);
		if (sel[JB_LOW_LEFT] || sel[JB_LOW_RIGHT]) begin
			e_row = REG_BITS'(row_q) + 1'b1;
		end
		if (sel[JB_MID_RIGHT] || sel[JB_LOW_RIGHT]) begin
			e_col = REG_BITS'(col_q) + 1'b1;
		end
		cnt_inc = (cnt_q == {CNT_BITS{1'b1}}) ? cnt_q : cnt_q + 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= '0;
		end else if (load) begin
			mask_q <= head_job.mask;
		end else if (emit) begin
			mask_q <= rest;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			row_q <= head_job.row;
			col_q <= head_job.col;
		end
	end

	// Running peak count and target flag, cleared by the summary.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			hit_q <= 1'b0;
		end else if (emit) begin
			if (sel[JB_SUMMARY]) begin
				cnt_q <= '0;
				hit_q <= 1'b0;
			end else begin
				cnt_q <= cnt_inc;
				if (e_row == cfg.target_row && e_col == cfg.target_col) begin
					hit_q <= 1'b1;
				end
			end
		end
	end

	// Output register; a new result loads when it is empty or the old one is transferred.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			if (sel[JB_SUMMARY]) begin
				item_kind      <= KIND_SUMMARY;
				peak_row       <= '0;
				peak_col       <= '0;
				peak_ordinal   <= cnt_q;
				target_is_peak <= hit_q;
				last_of_run    <= 1'b1;
			end else begin
				item_kind      <= KIND_PEAK;
				peak_row       <= e_row;
				peak_col       <= e_col;
				peak_ordinal   <= cnt_inc;
				target_is_peak <= 1'b0;
				last_of_run    <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

endmodule

// ===== rtl/grid_local_maximum_finder.sv =====
// Finds strict 3x3 local maxima in a grid streamed in raster order.
// Input channel: in_valid/in_stall with cell_value, one cell per transfer,
// accepted at a rising edge with in_valid high and in_stall low.
// Configuration: cfg_valid/cfg_ready with cfg_index and cfg_data; cfg_ready is
// always high. Registers: grid_rows, grid_cols, target_row, target_col. Write
// them only while the block is idle.
// Output channel: out_valid/out_stall. Each peak gives one report item with its
// 1-based row, column and running ordinal; the final cell of a grid gives up
// to four reports and then a summary item with last_of_run set.
// Throughput: one cell per cycle while in_stall is low. A cell waits in stage
// one of the front while its column is read from the line store, which has one
// read and one write port; results then pass a four-entry job queue and leave
// through the output register, one per cycle while out_stall is low.
// When out_stall holds, the output register and the job queue fill, and the
// front then raises in_stall; nothing is dropped.
// Reset clears position, count, window and queue; line store contents are
// unknown after reset; stale entries are read but never enabled in a decision.
module grid_local_maximum_finder import glmf_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [IDX_BITS-1:0]   cfg_index,
	input  logic [REG_BITS-1:0]   cfg_data,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [VALUE_BITS-1:0] cell_value,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic                  item_kind,
	output logic [REG_BITS-1:0]   peak_row,
	output logic [REG_BITS-1:0]   peak_col,
	output logic [CNT_BITS-1:0]   peak_ordinal,
	output logic                  target_is_peak,
	output logic                  last_of_run
);

	glmf_cfg_t   cfg_q;
	glmf_job_t   push_job, head_job;
	glmf_qstat_t q_stat;
	logic        push, pop;

	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.grid_rows  <= REG_BITS'(2);
			cfg_q.grid_cols  <= REG_BITS'(2);
			cfg_q.target_row <= REG_BITS'(1);
			cfg_q.target_col <= REG_BITS'(1);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_GRID_ROWS:  cfg_q.grid_rows  <= cfg_data;
				REG_GRID_COLS:  cfg_q.grid_cols  <= cfg_data;
				REG_TARGET_ROW: cfg_q.target_row <= cfg_data;
				REG_TARGET_COL: cfg_q.target_col <= cfg_data;
				default: ;
			endcase
		end
	end

	glmf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.cell_value (cell_value),
		.q_full     (q_stat.full),
		.push       (push),
		.push_job   (push_job)
	);

	glmf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head_job (head_job),
		.stat     (q_stat)
	);

	glmf_back u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.head_job       (head_job),
		.q_empty        (q_stat.empty),
		.pop            (pop),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.item_kind      (item_kind),
		.peak_row       (peak_row),
		.peak_col       (peak_col),
		.peak_ordinal   (peak_ordinal),
		.target_is_peak (target_is_peak),
		.last_of_run    (last_of_run)
	);

	// The queue is never written while full nor read while empty.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && q_stat.full))
		else $error("job pushed into a full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && q_stat.empty))
		else $error("job popped from an empty queue");

	// Summary items carry last_of_run, and reports carry a real position.
	a_last_is_summary: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (last_of_run == (item_kind == KIND_SUMMARY)))
		else $error("last_of_run does not match item kind");

	a_report_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && item_kind == KIND_PEAK) |->
		(peak_row != '0 && peak_col != '0 && peak_ordinal != '0))
		else $error("peak report with zero row, column or ordinal");

endmodule
